// ----- design/ksm_pkg.sv -----
// Shared types and constants for the k-way sorted merge block.
package ksm_pkg;

    localparam int KIND_W = 2;
    localparam int LID_W  = 3;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 3;

    // Request kinds; the unused code decodes as clear.
    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 2'd0,
        KIND_POP    = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_APPENDED = 3'd0,
        ST_DROPPED  = 3'd1,
        ST_POPPED   = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_CLEARED  = 3'd4
    } status_t;

endpackage

// ----- design/ksm_if.sv -----
// Request and result channel interfaces for the k-way sorted merge block.
interface ksm_req_if import ksm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic [LID_W-1:0]        list_id;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output kind, output list_id, output value, input ready);
    modport sink   (input valid, input kind, input list_id, input value, output ready);
endinterface

interface ksm_rsp_if import ksm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] out_value;
    logic [LID_W-1:0]        source_list;

    modport source (output valid, output status, output out_value, output source_list,
                    input ready);
    modport sink   (input valid, input status, input out_value, input source_list,
                    output ready);
endinterface

// ----- design/ksm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ksm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/k_way_sorted_merge.sv -----
// Top level of the k-way sorted merge: per-list FIFOs and a min-head selector.
//
//   channel | role   | payload                          | one request means
//   --------+--------+----------------------------------+-----------------------------
//   req     | sink   | kind, list_id, value             | append / pop / clear
//   rsp     | source | status, out_value, source_list   | exactly one result per req
//
// One request per cycle sustained while the result side takes results; a result
// passes from the input register, loaded on the accepting edge, to the result register.
// The rate is set by the per-list RAM read port, which follows each list's head
// pointer every cycle.
// Reset empties all lists at once (fill counts to zero); no clearing pass, the
// element storage is never read where a fill count says it holds nothing.
// A stalled result holds in the result register while the input register still
// takes one more request; ready drops only when both are occupied.
module k_way_sorted_merge import ksm_pkg::*; #(
    parameter int NUM_LISTS  = 8,
    parameter int LIST_DEPTH = 64
) (
    input logic       clk,
    input logic       rst_n,
    ksm_req_if.sink   req,
    ksm_rsp_if.source rsp
);

    localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int PTR_W  = $clog2(LIST_DEPTH);
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int TREE_N = 1 << LIST_W;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(LIST_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LIST_DEPTH);

    // Input register
    logic                    s1_valid_reg, s1_valid_next;
    logic [KIND_W-1:0]       s1_kind_reg, s1_kind_next;
    logic [LID_W-1:0]        s1_list_reg, s1_list_next;
    logic signed [VAL_W-1:0] s1_value_reg, s1_value_next;

    // Result register
    logic                    out_valid_reg, out_valid_next;
    status_t                 out_status_reg, out_status_next;
    logic signed [VAL_W-1:0] out_value_reg, out_value_next;
    logic [LID_W-1:0]        out_src_reg, out_src_next;

    // Per-list pointers and counts
    logic [PTR_W-1:0] head_reg [NUM_LISTS];
    logic [PTR_W-1:0] head_next [NUM_LISTS];
    logic [PTR_W-1:0] tail_reg [NUM_LISTS];
    logic [PTR_W-1:0] tail_next [NUM_LISTS];
    logic [CNT_W-1:0] fill_reg [NUM_LISTS];
    logic [CNT_W-1:0] fill_next [NUM_LISTS];

    // Write-to-empty forwarding: RAM read of the same slot returns old data
    logic [NUM_LISTS-1:0]    fwd_hit_reg, fwd_hit_next;
    logic signed [VAL_W-1:0] fwd_data_reg, fwd_data_next;

    logic [VAL_W-1:0]        rd_data [NUM_LISTS];
    logic signed [VAL_W-1:0] head_val [NUM_LISTS];
    logic [NUM_LISTS-1:0]    nonempty;
    logic [NUM_LISTS-1:0]    full;
    logic [NUM_LISTS-1:0]    sel_list;
    logic [NUM_LISTS-1:0]    pop_sel;
    logic [NUM_LISTS-1:0]    we;

    // Min-head tree, heap order: node 1 is the root, leaves start at TREE_N
    logic                    node_valid [1:2*TREE_N-1];
    logic signed [VAL_W-1:0] node_val [1:2*TREE_N-1];
    logic [LIST_W-1:0]       node_idx [1:2*TREE_N-1];

    logic out_free;
    logic process;
    logic is_append;
    logic is_pop;
    logic is_clear;
    logic lid_ok;
    logic append_ok;
    logic pop_ok;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign process   = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || out_free;

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.out_value   = out_value_reg;
    assign rsp.source_list = out_src_reg;

    // Current head of each list: RAM output, or the value just written to an empty list
    always_comb
    begin
        for (int i = 0; i < NUM_LISTS; i++)
        begin
            head_val[i] = fwd_hit_reg[i] ? fwd_data_reg : $signed(rd_data[i]);
            nonempty[i] = (fill_reg[i] != '0);
            full[i]     = (fill_reg[i] == CNT_FULL);
        end
    end

    // Kind decode
    always_comb
    begin
        is_append = 1'b0;
        is_pop    = 1'b0;
        is_clear  = 1'b0;
        case (kind_t'(s1_kind_reg))
            KIND_APPEND: is_append = 1'b1;
            KIND_POP:    is_pop    = 1'b1;
            default:     is_clear  = 1'b1;
        endcase
    end

    // Smallest head; on a tie the left (lower-numbered) list keeps the win
    always_comb
    begin
        node_valid[1] = 1'b0;
        node_val[1]   = '0;
        node_idx[1]   = '0;
        for (int k = TREE_N; k < 2 * TREE_N; k++)
        begin
            if (k - TREE_N < NUM_LISTS)
            begin
                node_valid[k] = nonempty[k - TREE_N];
                node_val[k]   = head_val[k - TREE_N];
            end
            else
            begin
                node_valid[k] = 1'b0;
                node_val[k]   = '0;
            end
            node_idx[k] = LIST_W'(k - TREE_N);
        end
        for (int k = TREE_N - 1; k >= 1; k--)
        begin
            if (node_valid[2*k+1] &&
                (!node_valid[2*k] || (node_val[2*k+1] < node_val[2*k])))
            begin
                node_valid[k] = 1'b1;
                node_val[k]   = node_val[2*k+1];
                node_idx[k]   = node_idx[2*k+1];
            end
            else
            begin
                node_valid[k] = node_valid[2*k];
                node_val[k]   = node_val[2*k];
                node_idx[k]   = node_idx[2*k];
            end
        end
    end

    // List select, full check and per-list updates
    always_comb
    begin
        lid_ok = (int'(s1_list_reg) < NUM_LISTS);
        for (int i = 0; i < NUM_LISTS; i++)
        begin
            sel_list[i] = lid_ok && (int'(s1_list_reg) == i);
        end
        append_ok = is_append && lid_ok && !(|(sel_list & full));
        pop_ok    = is_pop && node_valid[1];

        for (int i = 0; i < NUM_LISTS; i++)
        begin
            pop_sel[i] = process && pop_ok && (node_idx[1] == LIST_W'(i));
            we[i]      = process && append_ok && sel_list[i];

            if (process && is_clear)
            begin
                head_next[i] = '0;
                tail_next[i] = '0;
                fill_next[i] = '0;
            end
            else
            begin
                head_next[i] = head_reg[i];
                tail_next[i] = tail_reg[i];
                fill_next[i] = fill_reg[i];
                if (pop_sel[i])
                begin
                    head_next[i] = (head_reg[i] == PTR_LAST) ? '0 : head_reg[i] + 1'b1;
                    fill_next[i] = fill_reg[i] - 1'b1;
                end
                if (we[i])
                begin
                    tail_next[i] = (tail_reg[i] == PTR_LAST) ? '0 : tail_reg[i] + 1'b1;
                    fill_next[i] = fill_reg[i] + 1'b1;
                end
            end
            // appending to an empty list writes the slot the head is reading
            fwd_hit_next[i] = we[i] && !nonempty[i];
        end
        fwd_data_next = s1_value_reg;
    end

    // Input register load
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_kind_next  = s1_kind_reg;
        s1_list_next  = s1_list_reg;
        s1_value_next = s1_value_reg;
        if (req.valid && req.ready)
        begin
            s1_valid_next = 1'b1;
            s1_kind_next  = req.kind;
            s1_list_next  = req.list_id;
            s1_value_next = req.value;
        end
        else if (process)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Result register load
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_src_next    = out_src_reg;
        if (process)
        begin
            out_valid_next = 1'b1;
            out_value_next = '0;
            out_src_next   = '0;
            if (is_append)
            begin
                out_status_next = append_ok ? ST_APPENDED : ST_DROPPED;
            end
            else if (is_pop)
            begin
                if (pop_ok)
                begin
                    out_status_next = ST_POPPED;
                    out_value_next  = node_val[1];
                    out_src_next    = LID_W'(node_idx[1]);
                end
                else
                begin
                    out_status_next = ST_EMPTY;
                end
            end
            else
            begin
                out_status_next = ST_CLEARED;
            end
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= '0;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            fwd_hit_reg   <= fwd_hit_next;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                head_reg[i] <= head_next[i];
                tail_reg[i] <= tail_next[i];
                fill_reg[i] <= fill_next[i];
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        s1_kind_reg    <= s1_kind_next;
        s1_list_reg    <= s1_list_next;
        s1_value_reg   <= s1_value_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_src_reg    <= out_src_next;
        fwd_data_reg   <= fwd_data_next;
    end

    // One element RAM per list; its read port always tracks the next head slot
    for (genvar g = 0; g < NUM_LISTS; g++)
    begin : g_list
        ksm_ram #(
            .WIDTH (VAL_W),
            .DEPTH (LIST_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (we[g]),
            .waddr (tail_reg[g]),
            .wdata (s1_value_reg),
            .raddr (head_next[g]),
            .rdata (rd_data[g])
        );
    end

endmodule

// ----- design/ksm_checker.sv -----
// Port-level checks for the k-way sorted merge, bound to the top level.
module ksm_checker import ksm_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [STAT_W-1:0] rsp_status,
    input logic [VAL_W-1:0]  rsp_out_value,
    input logic [LID_W-1:0]  rsp_source_list
);

    // a stalled result keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            rsp_valid && $stable(rsp_status) && $stable(rsp_out_value) &&
            $stable(rsp_source_list))
        else $error("stalled result changed");

    // only a popped result carries a value and a source list
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_POPPED) |->
            (rsp_out_value == '0) && (rsp_source_list == '0))
        else $error("non-pop result has nonzero value or source");

    // request taken while the result is stalled fills the input register
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready && req_valid && req_ready |=> (rsp_ready || !req_ready))
        else $error("ready high with both stages occupied");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !rsp_valid)
        else $error("result valid right after reset");

endmodule

bind k_way_sorted_merge ksm_checker u_ksm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_out_value   (rsp.out_value),
    .rsp_source_list (rsp.source_list)
);

// ----- bench/tb_k_way_sorted_merge.sv -----
// Self-checking testbench for the k-way sorted merge block: random sorted-list traffic.
module tb_k_way_sorted_merge import ksm_pkg::*; ;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_LISTS  = 8;
    localparam int LIST_DEPTH = 64;

    // Unused kind code; the block decodes it as a clear.
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam longint VAL_MAX = 64'sd2147483647;
    localparam longint VAL_MIN = -64'sd2147483648;

    localparam int PHASE_ITEMS = 330;   // random requests per idling phase
    localparam int LONG_HOLD   = 300;   // cycles the result side holds off

    typedef struct {
        logic [KIND_W-1:0]       kind;
        logic [LID_W-1:0]        list_id;
        logic signed [VAL_W-1:0] value;
    } merge_req_t;

    typedef struct {
        status_t                 status;
        logic signed [VAL_W-1:0] out_value;
        logic [LID_W-1:0]        source_list;
    } merge_rsp_t;

    logic clk;
    logic rst_n;

    ksm_req_if req_bus ();
    ksm_rsp_if rsp_bus ();

    k_way_sorted_merge #(
        .NUM_LISTS  (NUM_LISTS),
        .LIST_DEPTH (LIST_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus.sink),
        .rsp   (rsp_bus.source)
    );

    // Requests waiting to be offered, and results owed by the block in order.
    merge_req_t merge_requests [$];
    merge_rsp_t results_due [$];

    // Mirror of the per-list FIFOs.
    logic signed [VAL_W-1:0] list_store [NUM_LISTS][LIST_DEPTH];
    int head_slot [NUM_LISTS];
    int tail_slot [NUM_LISTS];
    int list_fill [NUM_LISTS];

    // Last value appended per list by the stimulus; keeps the lists ascending.
    longint list_tail_value [NUM_LISTS];

    int send_idle_pct;
    int rcv_stall_pct;
    int hold_requests;
    int holds_seen;
    int hold_left;
    int queued_count;
    int mismatch_count;

    // 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        #5_000_000;
        $display("[k_way_sorted_merge] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Mirror of one request: updates the FIFOs and returns the result the block owes.
    function automatic merge_rsp_t merge_outcome(input logic [KIND_W-1:0] kind,
                                                 input logic [LID_W-1:0] lid,
                                                 input logic signed [VAL_W-1:0] value);
        merge_rsp_t              res;
        logic signed [VAL_W-1:0] best_val;
        int                      best;
        bit                      found;
        res.status      = ST_CLEARED;
        res.out_value   = '0;
        res.source_list = '0;
        best_val        = '0;
        best            = 0;
        found           = 1'b0;
        if (kind == KIND_APPEND)
        begin
            // Out-of-range list or full list: dropped, nothing changes.
            if (int'(lid) >= NUM_LISTS || list_fill[lid] >= LIST_DEPTH)
            begin
                res.status = ST_DROPPED;
            end
            else
            begin
                list_store[lid][tail_slot[lid]] = value;
                tail_slot[lid] = (tail_slot[lid] + 1) % LIST_DEPTH;
                list_fill[lid]++;
                res.status = ST_APPENDED;
            end
        end
        else if (kind == KIND_POP)
        begin
            // Strict less-than: the lowest-numbered list wins a tie.
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                if (list_fill[i] != 0 && (!found || list_store[i][head_slot[i]] < best_val))
                begin
                    found    = 1'b1;
                    best     = i;
                    best_val = list_store[i][head_slot[i]];
                end
            end
            if (!found)
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                head_slot[best] = (head_slot[best] + 1) % LIST_DEPTH;
                list_fill[best]--;
                res.status      = ST_POPPED;
                res.out_value   = best_val;
                res.source_list = LID_W'(best);
            end
        end
        else
        begin
            // Clear, and the spare kind that decodes as clear.
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                head_slot[i] = 0;
                tail_slot[i] = 0;
                list_fill[i] = 0;
            end
        end
        return res;
    endfunction

    // Request driver: predicts on acceptance, then offers the next queued request.
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        merge_req_t nxt;
        if (!rst_n)
        begin
            req_bus.valid   <= 1'b0;
            req_bus.kind    <= KIND_APPEND;
            req_bus.list_id <= '0;
            req_bus.value   <= '0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
                results_due.insert(results_due.size(),
                                   merge_outcome(req_bus.kind, req_bus.list_id,
                                                 req_bus.value));
            // valid stays up until the request is taken
            if (!req_bus.valid || req_bus.ready)
            begin
                if (merge_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = merge_requests.pop_front();
                    req_bus.valid   <= 1'b1;
                    req_bus.kind    <= nxt.kind;
                    req_bus.list_id <= nxt.list_id;
                    req_bus.value   <= nxt.value;
                end
                else
                begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result-side ready: random stalls, plus a long hold-off when one is requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            hold_left     <= 0;
            holds_seen    <= 0;
        end
        else if (holds_seen != hold_requests)
        begin
            holds_seen    <= hold_requests;
            hold_left     <= LONG_HOLD;
            rsp_bus.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
        end
        else
        begin
            rsp_bus.ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // Result checker: every accepted result against the oldest owed one.
    always @(posedge clk)
    begin : check_results
        merge_rsp_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (results_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result status=%0d value=%0d list=%0d",
                                          rsp_bus.status, rsp_bus.out_value,
                                          rsp_bus.source_list));
            end
            else
            begin
                want = results_due.pop_front();
                if (rsp_bus.status !== want.status || rsp_bus.out_value !== want.out_value
                    || rsp_bus.source_list !== want.source_list)
                    report_mismatch($sformatf(
                        "status %0d/%0d value %0d/%0d list %0d/%0d (got/expected)",
                        rsp_bus.status, want.status, rsp_bus.out_value, want.out_value,
                        rsp_bus.source_list, want.source_list));
            end
        end
    end

    task automatic queue_request(input logic [KIND_W-1:0] kind, input int lid,
                                 input logic [VAL_W-1:0] value);
        merge_req_t r;
        r.kind    = kind;
        r.list_id = LID_W'(lid);
        r.value   = value;
        merge_requests.insert(merge_requests.size(), r);
        queued_count++;
    endtask

    // New random starting point for every list, sometimes the most negative value.
    task automatic restart_lists();
        for (int l = 0; l < NUM_LISTS; l++)
        begin
            list_tail_value[l] = longint'($signed($urandom));
            if ($urandom_range(7) == 0)
                list_tail_value[l] = VAL_MIN;
        end
    endtask

    // Append in ascending order: duplicates, small and large steps, saturating at max.
    task automatic queue_sorted_append(input int lid);
        queue_request(KIND_APPEND, lid, list_tail_value[lid][VAL_W-1:0]);
        case ($urandom_range(3))
            0: ;
            1: list_tail_value[lid] += $urandom_range(1, 3);
            2: list_tail_value[lid] += $urandom_range(0, 1000);
            default: list_tail_value[lid] += $urandom_range(0, 1 << 24);
        endcase
        if (list_tail_value[lid] > VAL_MAX)
            list_tail_value[lid] = VAL_MAX;
    endtask

    // Mostly sorted appends and pops, with a few unsorted appends as noise.
    task automatic queue_mixed_burst(input int count);
        int r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 55)
                queue_sorted_append($urandom_range(NUM_LISTS - 1));
            else if (r < 94)
                queue_request(KIND_POP, $urandom_range(NUM_LISTS - 1), $urandom);
            else
                queue_request(KIND_APPEND, $urandom_range(NUM_LISTS - 1), $urandom);
        end
    endtask

    task automatic queue_episode();
        int r;
        int lid;
        r = $urandom_range(99);
        if (r < 8)
        begin
            // Overfill one list past its depth, then drain well past empty.
            lid = $urandom_range(NUM_LISTS - 1);
            for (int n = 0; n < LIST_DEPTH + int'($urandom_range(1, 3)); n++)
                queue_sorted_append(lid);
            for (int n = 0; n < LIST_DEPTH + 4; n++)
                queue_request(KIND_POP, 0, '0);
        end
        else if (r < 15)
        begin
            queue_request($urandom_range(1) ? KIND_CLEAR : KIND_SPARE,
                          $urandom_range(NUM_LISTS - 1), $urandom);
            restart_lists();
        end
        else
        begin
            queue_mixed_burst(24);
        end
    endtask

    // Sender pause: nothing queued, nothing offered, nothing owed.
    task automatic drain_all();
        while (merge_requests.size() != 0 || req_bus.valid || results_due.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int phase_idle [4];
        int phase_stall [4];
        phase_idle     = '{0, 87, 0, 23};
        phase_stall    = '{0, 0, 87, 23};
        rst_n          = 1'b0;
        send_idle_pct  = 0;
        rcv_stall_pct  = 0;
        hold_requests  = 0;
        queued_count   = 0;
        mismatch_count = 0;
        for (int l = 0; l < NUM_LISTS; l++)
        begin
            head_slot[l] = 0;
            tail_slot[l] = 0;
            list_fill[l] = 0;
        end
        restart_lists();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: pop while empty, value extremes, equal heads, clears.
        queue_request(KIND_POP, 0, '0);
        queue_request(KIND_APPEND, 0, 32'h7fff_ffff);
        queue_request(KIND_APPEND, 7, 32'h8000_0000);
        queue_request(KIND_APPEND, 3, 32'h0000_0000);
        queue_request(KIND_APPEND, 5, 32'hffff_ffff);
        queue_request(KIND_APPEND, 6, 32'd5);
        queue_request(KIND_APPEND, 2, 32'd5);
        // min, -1, 0, tie on 5 goes to list 2, then list 6, max, then empty
        repeat (7) queue_request(KIND_POP, 7, 32'hffff_ffff);
        queue_request(KIND_APPEND, 1, 32'h5555_5555);
        queue_request(KIND_APPEND, 4, 32'haaaa_aaaa);
        queue_request(KIND_CLEAR, 0, '0);
        queue_request(KIND_POP, 0, '0);
        queue_request(KIND_APPEND, 4, 32'd42);
        queue_request(KIND_SPARE, 7, 32'hffff_ffff);
        queue_request(KIND_POP, 0, '0);
        drain_all();

        // Long result-side hold-off while requests keep coming: block fills and stalls.
        hold_requests++;
        queue_mixed_burst(48);
        drain_all();

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = phase_idle[p];
            rcv_stall_pct = phase_stall[p];
            queued_count  = 0;
            while (queued_count < PHASE_ITEMS)
                queue_episode();
            drain_all();
        end

        // Leave room for any stray result.
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("[k_way_sorted_merge] OK");
        else
            $display("[k_way_sorted_merge] ERROR");
        $finish;
    end

endmodule
